// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    // field widths
    localparam int CRD_W = 32;
    localparam int DST_W = 31;
    localparam int OFS_W = CRD_W + 1;

    // quadratic terms, sized for full precision
    localparam int A_W    = 2 * CRD_W;
    localparam int H_W    = CRD_W + OFS_W + 1;
    localparam int C_W    = 2 * CRD_W + 3;
    localparam int HM_W   = H_W - 1;
    localparam int CM_W   = C_W - 1;
    localparam int HL_W   = (HM_W + 1) / 2;
    localparam int CL_W   = CM_W / 2;
    localparam int AL_W   = A_W / 2;
    localparam int SQ_W   = 2 * HM_W;
    localparam int DISC_W = SQ_W + 2;

    // a nonnegative discriminant never exceeds a * r * r
    localparam int RAD_W  = 2 * (CRD_W + DST_W);
    localparam int ROOT_W = RAD_W / 2;

    localparam int NUM_W  = H_W + 1;
    localparam int QT_W   = DST_W;
    localparam int REM_W  = (A_W + QT_W > NUM_W - 1 + FRAC_BITS) ?
                            (A_W + QT_W) : (NUM_W - 1 + FRAC_BITS);

    typedef struct packed {
        logic        [DST_W-1:0] nearest_in;
        logic        [DST_W-1:0] radius;
        logic signed [CRD_W-1:0] center_z;
        logic signed [CRD_W-1:0] center_y;
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] dir_z;
        logic signed [CRD_W-1:0] dir_y;
        logic signed [CRD_W-1:0] dir_x;
        logic signed [CRD_W-1:0] origin_z;
        logic signed [CRD_W-1:0] origin_y;
        logic signed [CRD_W-1:0] origin_x;
    } rsi_ray_t;

    localparam int RAY_W   = $bits(rsi_ray_t);
    localparam int IN_TW   = ((RAY_W + 7) / 8) * 8;
    localparam int OUT_W   = 1 + DST_W;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    // side data that rides along with the discriminant and root
    typedef struct packed {
        logic signed [H_W-1:0]   h;
        logic        [A_W-1:0]   a;
        logic        [DST_W-1:0] nearest;
        logic                    miss;
    } rsi_carry_t;

    // side data for root selection and the divider
    typedef struct packed {
        logic                    ok;
        logic        [A_W-1:0]   a;
        logic        [DST_W-1:0] nearest;
    } rsi_div_t;

endpackage

// ===== sv/rsi_setup.sv =====
module rsi_setup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rsi_pkg::rsi_ray_t           in_ray,
    output logic                        out_valid,
    output rsi_pkg::rsi_carry_t         out_carry,
    output logic [rsi_pkg::RAD_W-1:0]   out_rad
);
    import rsi_pkg::*;

    localparam int NSTG  = 7;
    localparam int DD_W  = 2 * CRD_W - 1;
    localparam int DOT_W = CRD_W + OFS_W;
    localparam int OO_W  = 2 * CRD_W;
    localparam int RR_W  = 2 * DST_W;
    localparam int HH_W  = HM_W - HL_W;
    localparam int CH_W  = CM_W - CL_W;
    localparam int AH_W  = A_W - AL_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    // stage 1: offsets
    logic signed [CRD_W-1:0] d_reg [3];
    logic signed [CRD_W-1:0] d_next [3];
    logic signed [OFS_W-1:0] o_reg [3];
    logic signed [OFS_W-1:0] o_next [3];
    logic [DST_W-1:0]        r_reg, r_next;
    logic [DST_W-1:0]        n1_reg, n1_next;

    // stage 2: lane products
    logic signed [2*CRD_W-1:0] dsq [3];
    logic signed [2*OFS_W-1:0] osq [3];
    logic [DD_W-1:0]           dd_reg [3];
    logic [DD_W-1:0]           dd_next [3];
    logic signed [DOT_W-1:0]   dot_reg [3];
    logic signed [DOT_W-1:0]   dot_next [3];
    logic [OO_W-1:0]           oo_reg [3];
    logic [OO_W-1:0]           oo_next [3];
    logic [RR_W-1:0]           rr_reg, rr_next;
    logic [DST_W-1:0]          n2_reg, n2_next;

    // stage 3: a, h, c
    logic [A_W-1:0]            a3_reg, a3_next;
    logic signed [H_W-1:0]     h3_reg, h3_next;
    logic signed [C_W-1:0]     c3_reg, c3_next;
    logic [DST_W-1:0]          n3_reg, n3_next;

    // stage 4: magnitudes
    logic signed [H_W-1:0]     habs;
    logic signed [C_W-1:0]     cabs;
    logic [HM_W-1:0]           hm_reg, hm_next;
    logic [CM_W-1:0]           cm_reg, cm_next;
    logic                      cn4_reg, cn4_next;
    rsi_carry_t                k4_reg, k4_next;

    // stage 5: partial products
    logic [2*HH_W-1:0]         phh_reg, phh_next;
    logic [HH_W+HL_W-1:0]      phx_reg, phx_next;
    logic [2*HL_W-1:0]         pll_reg, pll_next;
    logic [AH_W+CH_W-1:0]      pahch_reg, pahch_next;
    logic [AH_W+CL_W-1:0]      pahcl_reg, pahcl_next;
    logic [AL_W+CH_W-1:0]      palch_reg, palch_next;
    logic [AL_W+CL_W-1:0]      palcl_reg, palcl_next;
    logic                      cn5_reg, cn5_next;
    rsi_carry_t                k5_reg, k5_next;

    // stage 6: h*h and a*|c|
    logic [SQ_W-1:0]           hsq_reg, hsq_next;
    logic [SQ_W-1:0]           ac_reg, ac_next;
    logic                      cn6_reg, cn6_next;
    rsi_carry_t                k6_reg, k6_next;

    // stage 7: discriminant
    logic signed [DISC_W-1:0]  disc;
    logic [RAD_W-1:0]          rad_reg, rad_next;
    rsi_carry_t                k7_reg, k7_next;

    assign v_next = {v_reg[NSTG-2:0], in_valid};

    always_comb
    begin
        d_next[0] = in_ray.dir_x;
        d_next[1] = in_ray.dir_y;
        d_next[2] = in_ray.dir_z;
        o_next[0] = OFS_W'(in_ray.origin_x) - OFS_W'(in_ray.center_x);
        o_next[1] = OFS_W'(in_ray.origin_y) - OFS_W'(in_ray.center_y);
        o_next[2] = OFS_W'(in_ray.origin_z) - OFS_W'(in_ray.center_z);
        r_next    = in_ray.radius;
        n1_next   = in_ray.nearest_in;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsq[i]      = d_reg[i] * d_reg[i];
            osq[i]      = o_reg[i] * o_reg[i];
            dd_next[i]  = dsq[i][DD_W-1:0];
            dot_next[i] = d_reg[i] * o_reg[i];
            oo_next[i]  = osq[i][OO_W-1:0];
        end
        rr_next = r_reg * r_reg;
        n2_next = n1_reg;
    end

    always_comb
    begin
        a3_next = A_W'(dd_reg[0]) + A_W'(dd_reg[1]) + A_W'(dd_reg[2]);
        h3_next = H_W'(dot_reg[0]) + H_W'(dot_reg[1]) + H_W'(dot_reg[2]);
        c3_next = C_W'(oo_reg[0]) + C_W'(oo_reg[1]) + C_W'(oo_reg[2]) - C_W'(rr_reg);
        n3_next = n2_reg;
    end

    always_comb
    begin
        habs            = h3_reg[H_W-1] ? -h3_reg : h3_reg;
        cabs            = c3_reg[C_W-1] ? -c3_reg : c3_reg;
        hm_next         = habs[HM_W-1:0];
        cm_next         = cabs[CM_W-1:0];
        cn4_next        = c3_reg[C_W-1];
        k4_next.h       = h3_reg;
        k4_next.a       = a3_reg;
        k4_next.nearest = n3_reg;
        k4_next.miss    = (a3_reg == '0);
    end

    always_comb
    begin
        phh_next   = hm_reg[HM_W-1:HL_W] * hm_reg[HM_W-1:HL_W];
        phx_next   = hm_reg[HM_W-1:HL_W] * hm_reg[HL_W-1:0];
        pll_next   = hm_reg[HL_W-1:0] * hm_reg[HL_W-1:0];
        pahch_next = k4_reg.a[A_W-1:AL_W] * cm_reg[CM_W-1:CL_W];
        pahcl_next = k4_reg.a[A_W-1:AL_W] * cm_reg[CL_W-1:0];
        palch_next = k4_reg.a[AL_W-1:0] * cm_reg[CM_W-1:CL_W];
        palcl_next = k4_reg.a[AL_W-1:0] * cm_reg[CL_W-1:0];
        cn5_next   = cn4_reg;
        k5_next    = k4_reg;
    end

    always_comb
    begin
        // cross term of the square is counted twice
        hsq_next = (SQ_W'(phh_reg) << (2 * HL_W)) + (SQ_W'(phx_reg) << (HL_W + 1))
                 + SQ_W'(pll_reg);
        ac_next  = (SQ_W'(pahch_reg) << (AL_W + CL_W)) + (SQ_W'(pahcl_reg) << AL_W)
                 + (SQ_W'(palch_reg) << CL_W) + SQ_W'(palcl_reg);
        cn6_next = cn5_reg;
        k6_next  = k5_reg;
    end

    always_comb
    begin
        disc         = cn6_reg ? (DISC_W'(hsq_reg) + DISC_W'(ac_reg))
                               : (DISC_W'(hsq_reg) - DISC_W'(ac_reg));
        k7_next      = k6_reg;
        k7_next.miss = k6_reg.miss || disc[DISC_W-1];
        rad_next     = k7_next.miss ? '0 : disc[RAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg      <= d_next;
            o_reg      <= o_next;
            r_reg      <= r_next;
            n1_reg     <= n1_next;
            dd_reg     <= dd_next;
            dot_reg    <= dot_next;
            oo_reg     <= oo_next;
            rr_reg     <= rr_next;
            n2_reg     <= n2_next;
            a3_reg     <= a3_next;
            h3_reg     <= h3_next;
            c3_reg     <= c3_next;
            n3_reg     <= n3_next;
            hm_reg     <= hm_next;
            cm_reg     <= cm_next;
            cn4_reg    <= cn4_next;
            k4_reg     <= k4_next;
            phh_reg    <= phh_next;
            phx_reg    <= phx_next;
            pll_reg    <= pll_next;
            pahch_reg  <= pahch_next;
            pahcl_reg  <= pahcl_next;
            palch_reg  <= palch_next;
            palcl_reg  <= palcl_next;
            cn5_reg    <= cn5_next;
            k5_reg     <= k5_next;
            hsq_reg    <= hsq_next;
            ac_reg     <= ac_next;
            cn6_reg    <= cn6_next;
            k6_reg     <= k6_next;
            rad_reg    <= rad_next;
            k7_reg     <= k7_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_carry = k7_reg;
    assign out_rad   = rad_reg;

endmodule

// ===== sv/rsi_sqrt.sv =====
module rsi_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rsi_pkg::RAD_W-1:0]   in_rad,
    input  rsi_pkg::rsi_carry_t         in_carry,
    output logic                        out_valid,
    output logic [rsi_pkg::ROOT_W-1:0]  out_root,
    output rsi_pkg::rsi_carry_t         out_carry
);
    import rsi_pkg::*;

    localparam int RM_W = ROOT_W + 2;
    localparam int RS_W = ROOT_W + 4;

    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0] v_next;
    logic [RAD_W-1:0]  x_reg [ROOT_W];
    logic [RM_W-1:0]   r_reg [ROOT_W];
    logic [ROOT_W-1:0] q_reg [ROOT_W];
    rsi_carry_t        k_reg [ROOT_W];

    assign v_next = {v_reg[ROOT_W-2:0], in_valid};

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stg
        logic [RAD_W-1:0]  x_in, x_next;
        logic [RM_W-1:0]   r_in, r_next;
        logic [ROOT_W-1:0] q_in, q_next;
        rsi_carry_t        k_in;
        logic [RS_W-1:0]   rs, trial, diff;
        logic              ge;

        if (i == 0)
        begin : g_head
            assign x_in = in_rad;
            assign r_in = '0;
            assign q_in = '0;
            assign k_in = in_carry;
        end
        else
        begin : g_body
            assign x_in = x_reg[i-1];
            assign r_in = r_reg[i-1];
            assign q_in = q_reg[i-1];
            assign k_in = k_reg[i-1];
        end

        always_comb
        begin
            rs     = {r_in, x_in[RAD_W-1 -: 2]};
            trial  = {2'b00, q_in, 2'b01};
            ge     = (rs >= trial);
            diff   = rs - trial;
            r_next = ge ? diff[RM_W-1:0] : rs[RM_W-1:0];
            q_next = {q_in[ROOT_W-2:0], ge};
            x_next = x_in << 2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                r_reg[i] <= r_next;
                q_reg[i] <= q_next;
                k_reg[i] <= k_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = q_reg[ROOT_W-1];
    assign out_carry = k_reg[ROOT_W-1];

endmodule

// ===== sv/rsi_select.sv =====
module rsi_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rsi_pkg::ROOT_W-1:0]  in_root,
    input  rsi_pkg::rsi_carry_t         in_carry,
    output logic                        out_valid,
    output logic [rsi_pkg::REM_W-1:0]   out_rem,
    output rsi_pkg::rsi_div_t           out_ctl
);
    import rsi_pkg::*;

    localparam int NSTG = 3;

    logic [NSTG-1:0]         v_reg, v_next;
    logic signed [NUM_W-1:0] nn_reg, nn_next;
    logic signed [NUM_W-1:0] nf_reg, nf_next;
    rsi_div_t                k1_reg, k1_next;
    logic signed [NUM_W-1:0] sel_reg, sel_next;
    rsi_div_t                k2_reg, k2_next;
    logic [REM_W-1:0]        x_reg, x_next;
    rsi_div_t                k3_reg, k3_next;
    logic [REM_W-1:0]        near_sh, sel_sh;

    assign v_next = {v_reg[NSTG-2:0], in_valid};

    always_comb
    begin
        nn_next         = -NUM_W'(in_carry.h) - NUM_W'(in_root);
        nf_next         = -NUM_W'(in_carry.h) + NUM_W'(in_root);
        k1_next.ok      = !in_carry.miss;
        k1_next.a       = in_carry.a;
        k1_next.nearest = in_carry.nearest;
    end

    // near root counts only if its truncated distance is at least one lsb
    always_comb
    begin
        near_sh  = REM_W'(nn_reg[NUM_W-2:0]) << FRAC_BITS;
        sel_next = (!nn_reg[NUM_W-1] && near_sh >= REM_W'(k1_reg.a)) ? nn_reg : nf_reg;
        k2_next  = k1_reg;
    end

    // quotient must land in [1, 2^QT_W) for the divider
    always_comb
    begin
        sel_sh     = REM_W'(sel_reg[NUM_W-2:0]) << FRAC_BITS;
        x_next     = sel_sh;
        k3_next    = k2_reg;
        k3_next.ok = k2_reg.ok && !sel_reg[NUM_W-1] && (sel_sh >= REM_W'(k2_reg.a))
                   && (sel_sh < (REM_W'(k2_reg.a) << QT_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn_reg  <= nn_next;
            nf_reg  <= nf_next;
            k1_reg  <= k1_next;
            sel_reg <= sel_next;
            k2_reg  <= k2_next;
            x_reg   <= x_next;
            k3_reg  <= k3_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_rem   = x_reg;
    assign out_ctl   = k3_reg;

endmodule

// ===== sv/rsi_div.sv =====
module rsi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rsi_pkg::REM_W-1:0]   in_rem,
    input  rsi_pkg::rsi_div_t           in_ctl,
    output logic                        out_valid,
    output logic [rsi_pkg::QT_W-1:0]    out_quot,
    output rsi_pkg::rsi_div_t           out_ctl
);
    import rsi_pkg::*;

    logic [QT_W-1:0]  v_reg, v_next;
    logic [REM_W-1:0] rem_reg [QT_W];
    logic [QT_W-1:0]  q_reg [QT_W];
    rsi_div_t         k_reg [QT_W];

    assign v_next = {v_reg[QT_W-2:0], in_valid};

    // restoring division, quotient msb first
    for (genvar i = 0; i < QT_W; i++)
    begin : g_stg
        logic [REM_W-1:0] rem_in, rem_next, dv;
        logic [QT_W-1:0]  q_in, q_next;
        rsi_div_t         k_in;
        logic             ge;

        if (i == 0)
        begin : g_head
            assign rem_in = in_rem;
            assign q_in   = '0;
            assign k_in   = in_ctl;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign k_in   = k_reg[i-1];
        end

        always_comb
        begin
            dv       = REM_W'(k_in.a) << (QT_W - 1 - i);
            ge       = (rem_in >= dv);
            rem_next = ge ? (rem_in - dv) : rem_in;
            q_next   = {q_in[QT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= q_next;
                k_reg[i]   <= k_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    assign out_valid = v_reg[QT_W-1];
    assign out_quot  = q_reg[QT_W-1];
    assign out_ctl   = k_reg[QT_W-1];

endmodule

// ===== sv/ray_sphere_intersect_unit.sv =====
// pipeline: setup, square root, root select and divide stages, then an output
// register, from input beat to output beat
// throughput: one beat per cycle unless a held output beat stalls; the one-bit-per-stage
// square root and divider pipelines set the depth, and a stall holds all stages in place
// reset: rst_n clears all valid bits, output valid included, asynchronously;
// data registers are not reset
module ray_sphere_intersect_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, radius, nearest_in, zero pad
    input  logic [rsi_pkg::IN_TW-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, nearest_out
    output logic [rsi_pkg::OUT_TW-1:0]  m_tdata
);
    import rsi_pkg::*;

    logic                en;
    logic                out_free;
    rsi_ray_t            ray;

    logic                su_valid;
    rsi_carry_t          su_carry;
    logic [RAD_W-1:0]    su_rad;

    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    rsi_carry_t          sq_carry;

    logic                sl_valid;
    logic [REM_W-1:0]    sl_rem;
    rsi_div_t            sl_ctl;

    logic                div_valid;
    logic [QT_W-1:0]     div_quot;
    rsi_div_t            div_ctl;

    logic                out_valid_reg;
    logic                hit_reg, hit_next;
    logic [DST_W-1:0]    dist_reg, dist_next;

    assign ray      = rsi_ray_t'(s_tdata[RAY_W-1:0]);
    assign out_free = !out_valid_reg || m_tready;
    assign en       = out_free || !div_valid;
    assign s_tready = en;

    rsi_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_ray    (ray),
        .out_valid (su_valid),
        .out_carry (su_carry),
        .out_rad   (su_rad)
    );

    rsi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (su_valid),
        .in_rad    (su_rad),
        .in_carry  (su_carry),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_carry (sq_carry)
    );

    rsi_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_carry  (sq_carry),
        .out_valid (sl_valid),
        .out_rem   (sl_rem),
        .out_ctl   (sl_ctl)
    );

    rsi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sl_valid),
        .in_rem    (sl_rem),
        .in_ctl    (sl_ctl),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_ctl   (div_ctl)
    );

    always_comb
    begin
        hit_next  = div_ctl.ok && (div_quot <= div_ctl.nearest);
        dist_next = hit_next ? div_quot : div_ctl.nearest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && div_valid)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({dist_reg, hit_reg});

    // input side only stalls behind a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // a hit always carries a distance of at least one lsb
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[OUT_W-1:1] != '0))
        else $error("hit with zero distance");

    // no beat appears out of an empty pipeline
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        ((!m_tvalid || m_tready) && !div_valid) |=> !m_tvalid)
        else $error("output beat without a finished item");

endmodule

// ===== tb/sv/ray_sphere_intersect_unit_tb.sv =====
`timescale 1ns / 100ps

module ray_sphere_intersect_unit_tb;

    import rsi_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic             hit;
        logic [DST_W-1:0] nearest_out;
    } hit_rec_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_TW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_TW-1:0]   m_tdata;

    hit_rec_t hit_q[$];
    int       mismatches;
    int       beats_sent;
    int       beats_checked;
    int       hits_seen;
    int       burst_left;

    ray_sphere_intersect_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic wide_t int_sqrt(input wide_t x);
        wide_t res;
        wide_t cand;
        res = '0;
        for (int k = 95; k >= 0; k--)
        begin
            cand = res | (wide_t'(1) << k);
            if (cand * cand <= x)
                res = cand;
        end
        return res;
    endfunction

    // exact solve of |o + t*d - c| = r, nearest positive root within nearest_in
    function automatic hit_rec_t solve_sphere(input rsi_ray_t ray);
        hit_rec_t rec;
        wide_t dx, dy, dz, ox, oy, oz, rr, qa, qh, qc, disc, s, num, t;
        logic  pos;
        rec.hit = 1'b0;
        rec.nearest_out = ray.nearest_in;
        dx = ray.dir_x;
        dy = ray.dir_y;
        dz = ray.dir_z;
        ox = ray.origin_x;
        oy = ray.origin_y;
        oz = ray.origin_z;
        ox = ox - wide_t'(ray.center_x);
        oy = oy - wide_t'(ray.center_y);
        oz = oz - wide_t'(ray.center_z);
        rr = {161'b0, ray.radius};
        qa = dx * dx + dy * dy + dz * dz;
        qh = dx * ox + dy * oy + dz * oz;
        qc = ox * ox + oy * oy + oz * oz - rr * rr;
        if (qa == 0)
            return rec;
        disc = qh * qh - qa * qc;
        if (disc < 0)
            return rec;
        s = int_sqrt(disc);
        pos = 1'b0;
        t = '0;
        num = -qh - s;
        if (num > 0)
        begin
            t = (num <<< FRAC_BITS) / qa;
            pos = (t != 0);
        end
        if (!pos)
        begin
            num = -qh + s;
            if (num > 0)
            begin
                t = (num <<< FRAC_BITS) / qa;
                pos = (t != 0);
            end
        end
        if (pos && t <= wide_t'({161'b0, ray.nearest_in}))
        begin
            rec.hit = 1'b1;
            rec.nearest_out = t[DST_W-1:0];
        end
        return rec;
    endfunction

    task automatic send_ray(input rsi_ray_t ray);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(3) == 0 ? $urandom_range(12, 1) : 0) @(negedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 20)
                                                  : $urandom_range(8, 1);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_TW'(ray);
        do
            @(posedge clk);
        while (!s_tready);
        hit_q.push_back(solve_sphere(ray));
        beats_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    function automatic rsi_ray_t ray_of(input int ox, oy, oz, dx, dy, dz,
                                        input int cx, cy, cz,
                                        input int r, n);
        rsi_ray_t ray;
        ray.origin_x = ox; ray.origin_y = oy; ray.origin_z = oz;
        ray.dir_x = dx; ray.dir_y = dy; ray.dir_z = dz;
        ray.center_x = cx; ray.center_y = cy; ray.center_z = cz;
        ray.radius = DST_W'(r);
        ray.nearest_in = DST_W'(n);
        return ray;
    endfunction

    task automatic test_directed;
        localparam int ONE = 1 << FRAC_BITS;
        localparam int FAR = 32'h7fffffff;
        // plain hit in front, then the same limited by nearest_in
        send_ray(ray_of(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, FAR));
        send_ray(ray_of(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, 9*ONE));
        send_ray(ray_of(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, 9*ONE - 1));
        send_ray(ray_of(0, 0, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, 0));
        // zero direction
        send_ray(ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, FAR));
        // clean miss, negative discriminant
        send_ray(ray_of(0, 0, 0, ONE, 0, 0, 10*ONE, 5*ONE, 0, ONE, FAR));
        // tangent
        send_ray(ray_of(0, ONE, 0, ONE, 0, 0, 10*ONE, 0, 0, ONE, FAR));
        // origin inside, far root used
        send_ray(ray_of(0, 0, 0, 0, ONE, 0, 0, 0, 0, 3*ONE, FAR));
        // sphere behind the ray
        send_ray(ray_of(0, 0, 0, -ONE, 0, 0, 10*ONE, 0, 0, ONE, FAR));
        // origin on the surface, far root zero
        send_ray(ray_of(ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, FAR));
        // tiny root that truncates to zero
        send_ray(ray_of(0, 0, 0, 32'h7fffffff, 0, 0, 2, 0, 0, 1, FAR));
        // zero radius on the ray
        send_ray(ray_of(0, 0, 0, ONE, ONE, 0, 4*ONE, 4*ONE, 0, 0, FAR));
        // field extremes
        send_ray(ray_of(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, FAR, FAR));
        send_ray(ray_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000, FAR, FAR));
        send_ray(ray_of(32'h80000000, 0, 0, 32'h80000000, 0, 0,
                        32'h7fffffff, 0, 0, 0, FAR));
        send_ray(ray_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, FAR, 0));
        send_ray(ray_of(0, 0, 0, 1, 0, 0, 100, 0, 0, 1, FAR));
        send_ray(ray_of(0, 0, 0, 0, 0, ONE, 0, 0, 32'h7fff0000, ONE, FAR));
    endtask

    // aimed rays with random content, most of them hit
    task automatic test_aimed(input int count);
        rsi_ray_t ray;
        int       span, ox, oy, oz, cx, cy, cz, nz;
        for (int i = 0; i < count; i++)
        begin
            span = ($urandom_range(9) == 0) ? 32'h3fffffff : (1 << $urandom_range(24, 8));
            ox = $urandom_range(2 * span) - span;
            oy = $urandom_range(2 * span) - span;
            oz = $urandom_range(2 * span) - span;
            cx = $urandom_range(2 * span) - span;
            cy = $urandom_range(2 * span) - span;
            cz = $urandom_range(2 * span) - span;
            nz = span >> $urandom_range(8, 1);
            ray = ray_of(ox, oy, oz,
                         (cx - ox) + $urandom_range(2 * nz) - nz,
                         (cy - oy) + $urandom_range(2 * nz) - nz,
                         (cz - oz) + $urandom_range(2 * nz) - nz,
                         cx, cy, cz, $urandom_range(span), 32'h7fffffff);
            if ($urandom_range(3) == 0)
                ray.radius = DST_W'($urandom_range(2 * span));
            if ($urandom_range(2) == 0)
                ray.nearest_in = DST_W'($urandom_range(3 << FRAC_BITS));
            send_ray(ray);
        end
    endtask

    task automatic test_noise(input int count);
        rsi_ray_t ray;
        for (int i = 0; i < count; i++)
        begin
            ray.origin_x = $urandom; ray.origin_y = $urandom; ray.origin_z = $urandom;
            ray.dir_x = $urandom; ray.dir_y = $urandom; ray.dir_z = $urandom;
            ray.center_x = $urandom; ray.center_y = $urandom; ray.center_z = $urandom;
            ray.radius = DST_W'($urandom);
            ray.nearest_in = DST_W'($urandom);
            send_ray(ray);
        end
    endtask

    // receiver stall pattern, stepping through four modes in turn
    int unsigned rx_cycle;
    always @(negedge clk)
    begin
        rx_cycle++;
        case ((rx_cycle / 256) % 4)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(3) != 0);
            2: m_tready = ((rx_cycle % 7) > 2);
            default: m_tready = ($urandom_range(1) == 1);
        endcase
    end

    always @(posedge clk)
    begin
        hit_rec_t exp_rec;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hit_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", m_tdata);
            end
            else
            begin
                exp_rec = hit_q.pop_front();
                beats_checked++;
                if (m_tdata[0])
                    hits_seen++;
                if (m_tdata[0] !== exp_rec.hit
                    || m_tdata[DST_W:1] !== exp_rec.nearest_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected hit %b dist %h, got hit %b dist %h",
                                 beats_checked, exp_rec.hit, exp_rec.nearest_out,
                                 m_tdata[0], m_tdata[DST_W:1]);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rx_cycle = 0;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        hits_seen = 0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed;
        test_aimed(750);
        test_noise(280);
        s_tvalid = 1'b0;
        while (hit_q.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        $display("sent %0d rays (directed, aimed, random), checked %0d beats, %0d hits",
                 beats_sent, beats_checked, hits_seen);
        $display("bursty sender and patterned receiver stalls, %0d mismatches", mismatches);
        if (mismatches == 0 && hit_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
